// File: rtl/cfts_pkg.sv
// ----------------------------------------------------------------------------
// cfts_pkg
// Shared types and constants for the cluster feedback term select core.
// ----------------------------------------------------------------------------
`default_nettype none
package cfts_pkg;

  localparam int unsigned MaxCandidates    = 64;
  localparam int unsigned MaxCentroidTerms = 256;

  localparam int unsigned IdW    = 32;
  localparam int unsigned CountW = 10;
  localparam int unsigned PctW   = 7;
  localparam int unsigned MinRelW = 11;

  // floor(x / 100) == (x * PctRecip) >> PctShift for x below 2^17
  localparam int unsigned PctRecip = 167773;
  localparam int unsigned PctShift = 24;
  localparam int unsigned RoundAdd = 50;

  typedef enum logic [1:0] {
    KIND_CENT = 2'd0,
    KIND_CAND = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic {
    REG_PCT0 = 1'b0,
    REG_PCT1 = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_THR1,
    ST_THR2,
    ST_SRCH,
    ST_WAIT,
    ST_WB,
    ST_B_INIT,
    ST_B_RD,
    ST_B_CMP,
    ST_B_END,
    ST_PUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic done;
    logic found;
  } srch_t;

endpackage
`default_nettype wire

// File: rtl/cfts_cent_store.sv
// ----------------------------------------------------------------------------
// cfts_cent_store
// Centroid term memory with a sequential match search, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cfts_cent_store #(
  parameter int unsigned Depth = cfts_pkg::MaxCentroidTerms
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(Depth+1)-1:0]   wr_addr_i,
  input  wire logic                         wr_ctype_i,
  input  wire logic [cfts_pkg::IdW-1:0]     wr_id_i,
  input  wire logic [$clog2(Depth+1)-1:0]   count_i,
  input  wire logic                         start_i,
  input  wire logic                         key_ctype_i,
  input  wire logic [cfts_pkg::IdW-1:0]     key_id_i,
  output cfts_pkg::srch_t                   status_o
);
  import cfts_pkg::*;

  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [IdW:0]  mem [Depth];
  logic [IdW:0]  rd_q;
  logic [CW-1:0] k_q;
  logic          run_q, rdv_q, hit_q;
  logic          more;

  assign more = (k_q < count_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[AW'(wr_addr_i)] <= {wr_ctype_i, wr_id_i};
    end
    if (more) begin
      rd_q <= mem[AW'(k_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      run_q <= 1'b0;
      rdv_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (start_i) begin
      k_q   <= '0;
      run_q <= 1'b1;
      rdv_q <= 1'b0;
      hit_q <= 1'b0;
    end else if (run_q) begin
      rdv_q <= more;
      if (more) begin
        k_q <= k_q + CW'(1);
      end
      if (rdv_q && (rd_q == {key_ctype_i, key_id_i})) begin
        hit_q <= 1'b1;
      end
      if (!more && !rdv_q) begin
        run_q <= 1'b0;
      end
    end
  end

  assign status_o.done  = run_q && !more && !rdv_q;
  assign status_o.found = hit_q;

endmodule
`default_nettype wire

// File: rtl/cluster_feedback_term_select_core.sv
// ----------------------------------------------------------------------------
// cluster_feedback_term_select_core
// Loads are taken while idle. A run reads each candidate and, for a non-query
// candidate under a nonzero rel_doc_count, walks the centroid store; each
// segment then computes its threshold and makes (kept terms + 1) scans of its
// candidates to emit the kept terms in order; a closing step ends the run.
// s_axis_tready is low during a run. Reset clears counts, overflow, thresholds
// and control; memories hold.
// ----------------------------------------------------------------------------
`default_nettype none
module cluster_feedback_term_select_core #(
  parameter int unsigned MaxCandidates    = cfts_pkg::MaxCandidates,
  parameter int unsigned MaxCentroidTerms = cfts_pkg::MaxCentroidTerms
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // ctype[0], term_id[32:1], is_query[33], rel_count[43:34],
  // rel_doc_count[53:44], zero[55:54]
  input  wire logic [55:0] s_axis_tdata,
  // kind[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // entry_index[5:0], out_term_id[37:6], out_ctype[38], out_is_query[39],
  // out_rel_count[49:40], overflow[50], zero[55:51]
  output logic [55:0]      m_axis_tdata,
  // none_kept[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import cfts_pkg::*;

  localparam int unsigned CCW = $clog2(MaxCandidates + 1);
  localparam int unsigned CAW = $clog2(MaxCandidates);
  localparam int unsigned ECW = $clog2(MaxCentroidTerms + 1);

  typedef struct packed {
    logic              kept;
    logic [CountW-1:0] count;
    logic              query;
    logic [IdW-1:0]    id;
    logic              ctype;
  } cand_t;

  typedef struct packed {
    logic [5:0]        idx;
    logic [IdW-1:0]    id;
    logic              ctype;
    logic              query;
    logic [CountW-1:0] count;
  } item_t;

  state_e state_q, state_d;

  logic [CCW-1:0] cand_cnt_q, cand_cnt_d;
  logic [ECW-1:0] cent_cnt_q, cent_cnt_d;
  logic           ovf_q, ovf_d;
  logic [PctW-1:0] pct0_q, pct1_q;
  logic [9:0]     rel_q, rel_d;
  logic           rel0_q, rel0_d;
  logic [CCW-1:0] i_q, i_d, s_q, s_d, e_q, e_d, j_q, j_d;
  logic           rc_q, rc_d;
  logic [16:0]    prod_q, prod_d;
  logic [MinRelW-1:0] minrel_q, minrel_d;
  logic           found_q, found_d;
  cand_t          cur_q, cur_d;
  item_t          best_q, best_d, pend_q, pend_d;
  logic           best_v_q, best_v_d, pend_v_q, pend_v_d;
  logic [IdW-1:0] prev_id_q, prev_id_d;
  logic [5:0]     prev_idx_q, prev_idx_d;
  logic           have_prev_q, have_prev_d;
  item_t          out_q, out_d;
  logic           out_none_q, out_none_d, out_ovf_q, out_ovf_d, out_last_q, out_last_d;
  logic           out_v_q, out_v_d;

  cand_t          cand_mem [MaxCandidates];
  cand_t          cand_rd_q;
  logic           cand_we;
  logic [CCW-1:0] cand_waddr, cand_raddr;
  cand_t          cand_wdata;

  logic           cent_we, srch_start;
  srch_t          srch;

  logic           in_acc;
  logic [1:0]     in_kind;
  logic           out_free;
  logic [34:0]    recip_prod;
  logic [CountW-1:0] wb_count;
  logic [5:0]     j_idx;
  logic           gt_prev, lt_best;

  assign in_kind       = s_axis_tuser;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_v_q || m_axis_tready;

  cfts_cent_store #(
    .Depth(MaxCentroidTerms)
  ) u_cent (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cent_we),
    .wr_addr_i  (cent_cnt_q),
    .wr_ctype_i (s_axis_tdata[0]),
    .wr_id_i    (s_axis_tdata[32:1]),
    .count_i    (cent_cnt_q),
    .start_i    (srch_start),
    .key_ctype_i(rc_q),
    .key_id_i   (cur_q.id),
    .status_o   (srch)
  );

  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_mem[CAW'(cand_waddr)] <= cand_wdata;
    end
    cand_rd_q <= cand_mem[CAW'(cand_raddr)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct0_q <= '0;
      pct1_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_PCT0: pct0_q <= cfg_data_i;
        REG_PCT1: pct1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cand_cnt_q  <= '0;
      cent_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      best_v_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      have_prev_q <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cand_cnt_q  <= cand_cnt_d;
      cent_cnt_q  <= cent_cnt_d;
      ovf_q       <= ovf_d;
      best_v_q    <= best_v_d;
      pend_v_q    <= pend_v_d;
      have_prev_q <= have_prev_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q      <= rel_d;
    rel0_q     <= rel0_d;
    i_q        <= i_d;
    s_q        <= s_d;
    e_q        <= e_d;
    j_q        <= j_d;
    rc_q       <= rc_d;
    prod_q     <= prod_d;
    minrel_q   <= minrel_d;
    found_q    <= found_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    pend_q     <= pend_d;
    prev_id_q  <= prev_id_d;
    prev_idx_q <= prev_idx_d;
    out_q      <= out_d;
    out_none_q <= out_none_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign recip_prod = 35'(17'(prod_q + 17'(RoundAdd))) * 35'(PctRecip);
  assign wb_count   = found_q ? cur_q.count : '0;
  assign j_idx      = 6'(j_q);

  always_comb begin
    if (rel0_q) begin
      gt_prev = !have_prev_q || (j_idx > prev_idx_q);
      lt_best = !best_v_q || (j_idx < best_q.idx);
    end else begin
      gt_prev = !have_prev_q || (cand_rd_q.id > prev_id_q) ||
                ((cand_rd_q.id == prev_id_q) && (j_idx > prev_idx_q));
      lt_best = !best_v_q || (cand_rd_q.id < best_q.id) ||
                ((cand_rd_q.id == best_q.id) && (j_idx < best_q.idx));
    end
  end

  always_comb begin
    state_d     = state_q;
    cand_cnt_d  = cand_cnt_q;
    cent_cnt_d  = cent_cnt_q;
    ovf_d       = ovf_q;
    rel_d       = rel_q;
    rel0_d      = rel0_q;
    i_d         = i_q;
    s_d         = s_q;
    e_d         = e_q;
    j_d         = j_q;
    rc_d        = rc_q;
    prod_d      = prod_q;
    minrel_d    = minrel_q;
    found_d     = found_q;
    cur_d       = cur_q;
    best_d      = best_q;
    best_v_d    = best_v_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    prev_id_d   = prev_id_q;
    prev_idx_d  = prev_idx_q;
    have_prev_d = have_prev_q;
    out_d       = out_q;
    out_none_d  = out_none_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;
    out_v_d     = out_v_q && !m_axis_tready;
    cand_we     = 1'b0;
    cand_waddr  = cand_cnt_q;
    cand_raddr  = i_q;
    cand_wdata  = cand_t'{kept: 1'b0, count: s_axis_tdata[43:34], query: s_axis_tdata[33],
                          id: s_axis_tdata[32:1], ctype: s_axis_tdata[0]};
    cent_we     = 1'b0;
    srch_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_e'(in_kind))
            KIND_CENT: begin
              if (cent_cnt_q < ECW'(MaxCentroidTerms)) begin
                cent_we    = 1'b1;
                cent_cnt_d = cent_cnt_q + ECW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            KIND_CAND: begin
              if (cand_cnt_q < CCW'(MaxCandidates)) begin
                cand_we    = 1'b1;
                cand_cnt_d = cand_cnt_q + CCW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            KIND_RUN: begin
              rel_d       = s_axis_tdata[53:44];
              rel0_d      = (s_axis_tdata[53:44] == '0);
              i_d         = '0;
              s_d         = '0;
              have_prev_d = 1'b0;
              pend_v_d    = 1'b0;
              state_d     = ST_A_RD;
            end
            default: ;
          endcase
        end
      end
      ST_A_RD: begin
        cand_raddr = i_q;
        if (i_q == cand_cnt_q) begin
          e_d     = i_q;
          state_d = ST_B_INIT;
        end else begin
          state_d = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        cur_d = cand_rd_q;
        if (!rel0_q && (i_q != s_q) && (cand_rd_q.ctype != rc_q)) begin
          e_d     = i_q;
          state_d = ST_B_INIT;
        end else if (i_q == s_q) begin
          rc_d    = cand_rd_q.ctype;
          state_d = ST_THR1;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_THR1: begin
        prod_d  = 17'(rel_q) * 17'(rc_q ? pct1_q : pct0_q);
        state_d = ST_THR2;
      end
      ST_THR2: begin
        minrel_d = recip_prod[PctShift +: MinRelW];
        state_d  = ST_SRCH;
      end
      ST_SRCH: begin
        if (rel0_q || cur_q.query) begin
          found_d = 1'b1;
          state_d = ST_WB;
        end else begin
          srch_start = 1'b1;
          state_d    = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (srch.done) begin
          found_d = srch.found;
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        cand_we    = 1'b1;
        cand_waddr = i_q;
        cand_wdata = cur_q;
        cand_wdata.count = wb_count;
        cand_wdata.kept  = rel0_q || cur_q.query ||
                           ({1'b0, wb_count} >= minrel_q);
        i_d     = i_q + CCW'(1);
        state_d = ST_A_RD;
      end
      ST_B_INIT: begin
        j_d      = s_q;
        best_v_d = 1'b0;
        state_d  = ST_B_RD;
      end
      ST_B_RD: begin
        cand_raddr = j_q;
        if (j_q == e_q) begin
          state_d = ST_B_END;
        end else begin
          state_d = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        if (cand_rd_q.kept && gt_prev && lt_best) begin
          best_v_d = 1'b1;
          best_d   = item_t'{idx: j_idx, id: cand_rd_q.id, ctype: cand_rd_q.ctype,
                             query: cand_rd_q.query, count: cand_rd_q.count};
        end
        j_d     = j_q + CCW'(1);
        state_d = ST_B_RD;
      end
      ST_B_END: begin
        if (best_v_q) begin
          if (pend_v_q) begin
            state_d = ST_PUSH;
          end else begin
            pend_d      = best_q;
            pend_v_d    = 1'b1;
            prev_id_d   = best_q.id;
            prev_idx_d  = best_q.idx;
            have_prev_d = 1'b1;
            state_d     = ST_B_INIT;
          end
        end else begin
          s_d         = e_q;
          i_d         = e_q;
          have_prev_d = 1'b0;
          state_d     = (e_q == cand_cnt_q) ? ST_FIN : ST_A_RD;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_d       = pend_q;
          out_none_d  = 1'b0;
          out_ovf_d   = ovf_q;
          out_last_d  = 1'b0;
          out_v_d     = 1'b1;
          pend_d      = best_q;
          prev_id_d   = best_q.id;
          prev_idx_d  = best_q.idx;
          have_prev_d = 1'b1;
          state_d     = ST_B_INIT;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d      = pend_v_q ? pend_q : '0;
          out_none_d = !pend_v_q;
          out_ovf_d  = ovf_q;
          out_last_d = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          cand_cnt_d = '0;
          cent_cnt_d = '0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, out_ovf_q, out_q.count, out_q.query, out_q.ctype,
                          out_q.id, out_q.idx};
  assign m_axis_tuser  = out_none_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Cluster feedback term select testbench
// Drives centroid loads, candidate loads and run commands into the core,
// predicts every emitted term from a local model of the stores and
// thresholds, and compares each output beat field by field. A directed
// table comes first, then one pass that overflows both stores, then random
// load-and-run sequences under random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import cfts_pkg::*;

  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned NumItems   = 460;

  typedef struct {
    kind_e       kind;
    logic        ctype;
    logic [31:0] id;
    logic        query;
    logic [9:0]  cnt;
    logic [9:0]  rel;
  } term_item_t;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] id;
    logic        ctype;
    logic        query;
    logic [9:0]  cnt;
    logic        none;
    logic        ovf;
    logic        last;
  } term_out_t;

  typedef struct {
    term_item_t it;
    bit         typed;
    term_out_t  res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = KIND_NONE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = REG_PCT0;
  logic [6:0] cfg_data_i = '0;

  cluster_feedback_term_select_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // local copy of the stores and thresholds
  logic        cand_ctype [MaxCandidates];
  logic [31:0] cand_id    [MaxCandidates];
  logic        cand_query [MaxCandidates];
  logic [9:0]  cand_cnt   [MaxCandidates];
  logic        cent_ctype [MaxCentroidTerms];
  logic [31:0] cent_id    [MaxCentroidTerms];
  int unsigned n_cand, n_cent;
  bit          ovf_flag;
  logic [6:0]  pct [2];

  term_out_t   kept_q[$];
  int unsigned errors, beats_out, runs_done, items_sent;
  bit          quiet;
  int unsigned watch;
  int unsigned stall_left;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %0s: got %0h want %0h (beat %0d)", what, got, want, beats_out);
    errors++;
  endtask

  function automatic bit in_cent(input logic ct, input logic [31:0] id);
    for (int unsigned i = 0; i < n_cent; i++)
      if (cent_ctype[i] == ct && cent_id[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  task automatic select_terms(input term_item_t it, input bit keep);
    term_out_t   r;
    term_out_t   res[$];
    int unsigned s, e, n, j, min_rel, v;
    int unsigned lst[MaxCandidates];
    int unsigned cv[MaxCandidates];
    case (it.kind)
      KIND_CENT: begin
        if (n_cent < MaxCentroidTerms) begin
          cent_ctype[n_cent] = it.ctype;
          cent_id[n_cent] = it.id;
          n_cent++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      KIND_CAND: begin
        if (n_cand < MaxCandidates) begin
          cand_ctype[n_cand] = it.ctype;
          cand_id[n_cand] = it.id;
          cand_query[n_cand] = it.query;
          cand_cnt[n_cand] = it.cnt;
          n_cand++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      KIND_RUN: begin
        if (it.rel == 0) begin
          for (int unsigned i = 0; i < n_cand; i++) begin
            r = '{i[5:0], cand_id[i], cand_ctype[i], cand_query[i], cand_cnt[i],
                  1'b0, ovf_flag, 1'b0};
            res.push_back(r);
          end
        end else begin
          s = 0;
          while (s < n_cand) begin
            e = s + 1;
            while (e < n_cand && cand_ctype[e] == cand_ctype[s]) e++;
            min_rel = (it.rel * pct[cand_ctype[s]] + RoundAdd) / 100;
            n = 0;
            for (int unsigned i = s; i < e; i++) begin
              v = cand_cnt[i];
              if (!cand_query[i] && !in_cent(cand_ctype[s], cand_id[i])) v = 0;
              if (cand_query[i] || v >= min_rel) begin
                j = n;
                while (j > 0 && cand_id[lst[j-1]] > cand_id[i]) begin
                  lst[j] = lst[j-1];
                  cv[j] = cv[j-1];
                  j--;
                end
                lst[j] = i;
                cv[j] = v;
                n++;
              end
            end
            for (j = 0; j < n; j++) begin
              r = '{lst[j][5:0], cand_id[lst[j]], cand_ctype[lst[j]], cand_query[lst[j]],
                    cv[j][9:0], 1'b0, ovf_flag, 1'b0};
              res.push_back(r);
            end
            s = e;
          end
        end
        if (res.size() == 0) begin
          r = '{default: '0};
          r.none = 1'b1;
          r.ovf = ovf_flag;
          res.push_back(r);
        end
        res[res.size()-1].last = 1'b1;
        if (keep) foreach (res[k]) kept_q.push_back(res[k]);
        n_cand = 0;
        n_cent = 0;
        ovf_flag = 1'b0;
        runs_done++;
      end
      default: ;
    endcase
  endtask

  task automatic send(input term_item_t it, input bit keep);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {2'b00, it.rel, it.cnt, it.query, it.id, it.ctype};
    do @(negedge clk_i); while (!s_axis_tready);
    select_terms(it, keep);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    pct[idx] = val;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_pct();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic term_item_t mk(input kind_e k, input int unsigned ct,
                                    input logic [31:0] id, input int unsigned q,
                                    input int unsigned c, input int unsigned rl);
    term_item_t t;
    t = '{k, ct[0], id, q[0], c[9:0], rl[9:0]};
    return t;
  endfunction

  function automatic logic [31:0] rand_id();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom;
  endfunction

  // output stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // check output beats and watch for a hang
  always @(negedge clk_i) begin
    term_out_t w;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        watch = 0;
      else
        watch++;
      if (watch >= WatchLimit) begin
        $display("watchdog expired with %0d beats pending", kept_q.size());
        $display("testbench: done, errors");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (kept_q.size() == 0) begin
          report("unexpected beat", m_axis_tdata, 0);
        end else begin
          w = kept_q.pop_front();
          if (m_axis_tdata[5:0] != w.idx) report("entry_index", m_axis_tdata[5:0], w.idx);
          if (m_axis_tdata[37:6] != w.id) report("term_id", m_axis_tdata[37:6], w.id);
          if (m_axis_tdata[38] != w.ctype) report("ctype", m_axis_tdata[38], w.ctype);
          if (m_axis_tdata[39] != w.query) report("is_query", m_axis_tdata[39], w.query);
          if (m_axis_tdata[49:40] != w.cnt) report("rel_count", m_axis_tdata[49:40], w.cnt);
          if (m_axis_tdata[50] != w.ovf) report("overflow", m_axis_tdata[50], w.ovf);
          if (m_axis_tuser != w.none) report("none_kept", m_axis_tuser, w.none);
          if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
        end
        beats_out++;
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    term_out_t   t;
    term_item_t  it;
    int unsigned ncent, ncand;
    n_cand = 0; n_cent = 0; ovf_flag = 0; pct[0] = 0; pct[1] = 0;
    errors = 0; beats_out = 0; runs_done = 0; items_sent = 0; quiet = 0; watch = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // run on empty stores after reset
    t = '{default: '0}; t.none = 1; t.last = 1;
    rows.push_back('{mk(KIND_RUN, 0, 0, 0, 0, 5), 1, t});
    rows.push_back('{mk(KIND_CAND, 0, 32'hFFFF_FFFF, 0, 'h3FF, 0), 0, t});
    t = '{6'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'h3FF, 1'b0, 1'b0, 1'b1};
    rows.push_back('{mk(KIND_RUN, 0, 0, 0, 0, 0), 1, t});
    rows.push_back('{mk(KIND_CENT, 0, 7, 0, 0, 0), 0, t});
    rows.push_back('{mk(KIND_CENT, 1, 9, 0, 0, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 0, 7, 0, 5, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 0, 3, 1, 0, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 0, 8, 0, 'h3FF, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 1, 9, 0, 10, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 1, 9, 1, 10, 0), 0, t});
    rows.push_back('{mk(KIND_CAND, 0, 0, 0, 4, 0), 0, t});
    rows.push_back('{mk(KIND_NONE, 1, 32'h5A5A_A5A5, 1, 'h2AA, 'h155), 0, t});
    rows.push_back('{mk(KIND_RUN, 0, 0, 0, 0, 10), 0, t});
    t = '{default: '0}; t.none = 1; t.last = 1;
    rows.push_back('{mk(KIND_RUN, 1, 0, 0, 0, 'h3FF), 1, t});
    rows.push_back('{mk(KIND_CAND, 1, 0, 0, 0, 0), 0, t});
    rows.push_back('{mk(KIND_RUN, 0, 0, 0, 0, 1), 0, t});

    write_reg(REG_PCT0, 7'd50);
    write_reg(REG_PCT1, 7'd100);
    foreach (rows[i]) begin
      send(rows[i].it, !rows[i].typed);
      if (rows[i].typed) kept_q.push_back(rows[i].res);
    end

    // one pass that overflows both stores
    drain();
    write_reg(REG_PCT0, 7'd127);
    write_reg(REG_PCT1, 7'd0);
    for (int i = 0; i < MaxCentroidTerms + 2; i++)
      send(mk(KIND_CENT, $urandom_range(0, 1), rand_id(), 0, 0, 0), 1);
    for (int i = 0; i < MaxCandidates + 2; i++)
      send(mk(KIND_CAND, i / 20, rand_id(), int'($urandom_range(0, 3) == 0),
              $urandom_range(0, 1023), 0), 1);
    send(mk(KIND_RUN, 0, 0, 0, 0, $urandom_range(1, 1023)), 1);

    while (items_sent < NumItems) begin
      if (items_sent % 70 < 12 && $urandom_range(0, 3) == 0) begin
        drain();
        write_reg(REG_PCT0, pick_pct());
        write_reg(REG_PCT1, pick_pct());
      end
      if (items_sent > NumItems - 50) quiet = 1;
      ncent = $urandom_range(0, 8);
      ncand = $urandom_range(1, 10);
      for (int unsigned i = 0; i < ncent; i++)
        send(mk(KIND_CENT, $urandom_range(0, 1), rand_id(), 0, 0, 0), 1);
      for (int unsigned i = 0; i < ncand; i++) begin
        it = mk(KIND_CAND, $urandom_range(0, 1), rand_id(), int'($urandom_range(0, 3) == 0),
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1023) : $urandom_range(0, 20),
                0);
        send(it, 1);
      end
      if ($urandom_range(0, 9) == 0)
        send(mk(KIND_NONE, $urandom_range(0, 1), $urandom, $urandom_range(0, 1),
                $urandom_range(0, 1023), $urandom_range(0, 1023)), 1);
      if ($urandom_range(0, 11) != 0)
        send(mk(KIND_RUN, 0, 0, 0, 0,
                ($urandom_range(0, 7) == 0) ? 0 :
                (($urandom_range(0, 1) != 0) ? $urandom_range(1, 40) : $urandom_range(1, 1023))),
             1);
    end
    send(mk(KIND_RUN, 0, 0, 0, 0, $urandom_range(0, 30)), 1);

    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d runs and %0d output beats across several threshold settings",
             runs_done, beats_out);
    if (errors == 0 && kept_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches, %0d beats never seen", errors, kept_q.size());
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/cfts_pkg.sv
rtl/cfts_cent_store.sv
rtl/cluster_feedback_term_select_core.sv
test/testbench.sv
